/* hdl/mbma_pkg.sv */
package mbma_pkg;

   // status bytes with a rule of their own
   localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
   localparam logic [7:0] STATUS_UNDEF    = 8'hF1;
   localparam logic [7:0] STATUS_SONG_POS = 8'hF2;
   localparam logic [7:0] STATUS_SONG_SEL = 8'hF3;
   localparam logic [7:0] STATUS_EOX      = 8'hF7;
   localparam logic [7:0] STATUS_NOTE_OFF_CH15 = 8'h8F;

   // upper nibbles
   localparam logic [3:0] KIND_PROG_CHANGE = 4'hC;
   localparam logic [3:0] KIND_CH_PRESSURE = 4'hD;
   localparam logic [3:0] KIND_SYSTEM      = 4'hF;

endpackage

/* hdl/midi_byte_message_assembler.sv */
// MIDI byte message assembler.
// req_ channel: one serialized MIDI byte per item (req_in_byte). Bytes are
// gathered into a buffer memory; each byte either restarts, extends, or is
// dropped, and the buffer is checked for a complete message.
// rsp_ channel: a completed message of two or more bytes comes out one byte
// per item, in order, with rsp_last high on its final byte. Nothing comes out
// while csr_port_open is 0; the message is still consumed.
// csr_ channel: writes port_open; always ready.
// Bytes that complete no message are taken back to back, with req_ready high.
// A byte that completes an n-byte message holds req_ready low until the last
// output byte is loaded, and longer while the receiver stalls: each output
// byte needs a buffer memory read (ST_READ) and then a load of the output
// register (ST_LOAD), which waits until the output register is free.
// The output register stays full while rsp_ready is low; the next input byte
// may be taken while the final byte still waits there.
// Reset empties the buffer (fill count to zero) and closes the port.
module midi_byte_message_assembler #(
   parameter int MAX_MESSAGE_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_port_open
);

   localparam int AW = $clog2(MAX_MESSAGE_BYTES);
   localparam int FW = $clog2(MAX_MESSAGE_BYTES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type      state_ff, state_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [7:0]     status_ff, status_in;
   logic           port_open_ff, port_open_in;
   logic [AW-1:0]  rd_idx_ff, rd_idx_in;
   logic [AW-1:0]  last_idx_ff, last_idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [7:0]     buf_mem [MAX_MESSAGE_BYTES];
   logic [7:0]     rd_data_ff;

   logic           accept;
   logic           is_8f, is_eox, restart, append, overflow, checked;
   logic           mem_we;
   logic [AW-1:0]  wr_addr;
   logic [FW-1:0]  n;
   logic [FW-1:0]  need;
   logic [7:0]     st_sel;
   logic           has_need, need_two, is_sysex, single;
   logic           complete, keep, emit, out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // byte classification and message check
   always_comb begin
      is_8f    = (req_in_byte == mbma_pkg::STATUS_NOTE_OFF_CH15);
      is_eox   = !is_8f && (req_in_byte == mbma_pkg::STATUS_EOX) && (fill_ff != '0) &&
                 (status_ff == mbma_pkg::STATUS_SYSEX);
      restart  = !is_8f && !is_eox && req_in_byte[7];
      append   = (is_8f && (fill_ff > FW'(1))) || is_eox ||
                 (!req_in_byte[7] && (fill_ff != '0));
      overflow = append && (fill_ff == FW'(MAX_MESSAGE_BYTES));
      checked  = restart || (append && !overflow);
      mem_we   = accept && checked;
      wr_addr  = restart ? '0 : fill_ff[AW-1:0];
      n        = restart ? FW'(1) : fill_ff + FW'(1);
      st_sel   = restart ? req_in_byte : status_ff;

      has_need = 1'b0;
      need_two = 1'b0;
      is_sysex = 1'b0;
      single   = 1'b0;
      if (st_sel[7:4] != mbma_pkg::KIND_SYSTEM) begin
         has_need = 1'b1;
         need_two = (st_sel[7:4] == mbma_pkg::KIND_PROG_CHANGE) ||
                    (st_sel[7:4] == mbma_pkg::KIND_CH_PRESSURE);
      end else if (st_sel == mbma_pkg::STATUS_SYSEX) begin
         is_sysex = 1'b1;
      end else if (st_sel == mbma_pkg::STATUS_SONG_POS) begin
         has_need = 1'b1;
      end else if (st_sel == mbma_pkg::STATUS_SONG_SEL) begin
         has_need = 1'b1;
         need_two = 1'b1;
      end else if (st_sel != mbma_pkg::STATUS_UNDEF && st_sel != mbma_pkg::STATUS_EOX) begin
         single = 1'b1;
      end
      need = need_two ? FW'(2) : FW'(3);

      if (has_need) begin
         complete = (n == need);
         keep     = (n < need);
      end else if (is_sysex) begin
         complete = (req_in_byte == mbma_pkg::STATUS_EOX);
         keep     = (req_in_byte != mbma_pkg::STATUS_EOX);
      end else begin
         complete = single;
         keep     = 1'b0;
      end

      emit = accept && checked && complete && (n > FW'(1)) && port_open_ff;
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      status_in    = status_ff;
      port_open_in = port_open_ff;
      rd_idx_in    = rd_idx_ff;
      last_idx_in  = last_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      out_free     = !rsp_valid_ff || rsp_ready;

      if (csr_valid && csr_ready) begin
         port_open_in = csr_port_open;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (restart) begin
                  status_in = req_in_byte;
               end
               if (!checked) begin
                  // overflow drops the whole message; ignored bytes change nothing
                  fill_in = overflow ? '0 : fill_ff;
               end else begin
                  fill_in = keep ? n : '0;
               end
               if (emit) begin
                  rd_idx_in   = '0;
                  last_idx_in = AW'(n - FW'(1));
                  state_in    = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data_ff;
               rsp_last_in  = (rd_idx_ff == last_idx_ff);
               if (rd_idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         port_open_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         port_open_ff <= port_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      rd_idx_ff   <= rd_idx_in;
      last_idx_ff <= last_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   // buffer memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[wr_addr] <= req_in_byte;
      end
      rd_data_ff <= buf_mem[rd_idx_ff];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_MESSAGE_BYTES))
      else $error("fill count beyond buffer size");

   a_empty_while_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (fill_ff == '0))
      else $error("buffer not cleared during emission");

   a_multi_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (last_idx_ff != '0 && rd_idx_ff <= last_idx_ff))
      else $error("emission of a single-byte message or index past end");

   a_emit_port: assert property (@(posedge clock) disable iff (reset)
      emit |=> (state_ff == ST_READ && rd_idx_ff == '0))
      else $error("completed message did not start emission");

endmodule

/* tb/sv/midi_byte_message_assembler_tb.sv */
module midi_byte_message_assembler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_MESSAGE_BYTES = 64;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int SETTLE_CYCLES     = 8;
   localparam int END_CYCLES        = 16;
   localparam int LONG_HOLD_CYCLES  = 300;

   localparam logic [7:0] NOTE_OFF_CH0      = 8'h80;
   localparam logic [7:0] NOTE_ON_CH0       = 8'h90;
   localparam logic [7:0] TUNE_REQUEST      = 8'hF6;
   localparam logic [7:0] SYSTEM_RESET      = 8'hFF;
   localparam logic [7:0] SINGLE_BYTE_FIRST = 8'hF4;
   localparam logic [3:0] KIND_NOTE_OFF     = 4'h8;
   localparam logic [3:0] KIND_PITCH_BEND   = 4'hE;
   localparam int         DATA_MAX          = 127;
   localparam int         BYTE_MAX          = 255;

   typedef enum {MSG_PENDING, MSG_DONE, MSG_DROP} msg_verdict_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } midi_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_port_open = 1'b0;

   // assembler model state
   logic [7:0]   msg_buf [0:MAX_MESSAGE_BYTES-1];
   int           msg_fill = 0;
   bit           port_open_q = 1'b0;
   midi_out_type expected_bytes [$];

   int error_count     = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int messages_seen   = 0;
   int quiet_cycles    = 0;
   int max_req_gap     = 6;
   int max_rsp_stall   = 6;
   int rsp_hold_request = 0;

   midi_byte_message_assembler #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_port_open(csr_port_open)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic bit buf_append(input logic [7:0] b);
      if (msg_fill >= MAX_MESSAGE_BYTES) begin
         msg_fill = 0;
         return 1'b0;
      end
      msg_buf[msg_fill] = b;
      msg_fill++;
      return 1'b1;
   endfunction

   function automatic msg_verdict_type classify_message();
      logic [7:0] st;
      int         need;
      st = msg_buf[0];
      need = 0;
      if (!st[7]) return MSG_DROP;
      if (st[7:4] != mbma_pkg::KIND_SYSTEM) begin
         need = (st[7:4] == mbma_pkg::KIND_PROG_CHANGE ||
                 st[7:4] == mbma_pkg::KIND_CH_PRESSURE) ? 2 : 3;
      end else if (st == mbma_pkg::STATUS_SYSEX) begin
         return (msg_buf[msg_fill-1] == mbma_pkg::STATUS_EOX) ? MSG_DONE : MSG_PENDING;
      end else if (st == mbma_pkg::STATUS_UNDEF || st == mbma_pkg::STATUS_EOX) begin
         return MSG_DROP;
      end else if (st == mbma_pkg::STATUS_SONG_POS) begin
         need = 3;
      end else if (st == mbma_pkg::STATUS_SONG_SEL) begin
         need = 2;
      end else begin
         return MSG_DONE;
      end
      if (msg_fill == need) return MSG_DONE;
      if (msg_fill > need) return MSG_DROP;
      return MSG_PENDING;
   endfunction

   // Fold one accepted byte into the model and queue whatever it emits.
   function automatic void assemble_byte(input logic [7:0] b);
      msg_verdict_type verdict;
      midi_out_type    item;
      if (b == mbma_pkg::STATUS_NOTE_OFF_CH15) begin
         if (msg_fill <= 1) return;
         if (!buf_append(b)) return;
      end else if (b == mbma_pkg::STATUS_EOX && msg_fill > 0 &&
                   msg_buf[0] == mbma_pkg::STATUS_SYSEX) begin
         if (!buf_append(b)) return;
      end else if (b[7]) begin
         msg_buf[0] = b;
         msg_fill = 1;
      end else begin
         if (msg_fill == 0) return;
         if (!buf_append(b)) return;
      end
      verdict = classify_message();
      if (verdict == MSG_PENDING) return;
      if (verdict == MSG_DONE && msg_fill > 1 && port_open_q) begin
         for (int i = 0; i < msg_fill; i++) begin
            item.out_byte = msg_buf[i];
            item.last = (i == msg_fill - 1);
            expected_bytes = {expected_bytes, item};
         end
      end
      msg_fill = 0;
   endfunction

   // check results before predicting: no byte can come out at its own input edge
   always @(posedge clock) begin
      midi_out_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (rsp_last) messages_seen++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %0b",
                                         rsp_out_byte, rsp_last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b on byte %02h, want %0b",
                                            rsp_last, rsp_out_byte, want.last));
            end
         end
         if (req_valid && req_ready) assemble_byte(req_in_byte);
         if (csr_valid && csr_ready) port_open_q = csr_port_open;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a handshake", quiet_cycles);
         $display("midi_byte_message_assembler_tb: FAIL");
         $finish;
      end
   end

   // receiver: random stall per item, or a long hold when one is requested
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            stall = rsp_hold_request;
            rsp_hold_request = 0;
         end else begin
            stall = $urandom_range(0, max_rsp_stall);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && rsp_hold_request == 0) @(posedge clock);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, max_req_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_port_open(input bit open);
      csr_valid <= 1'b1;
      csr_port_open <= open;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_data();
      return 8'($urandom_range(0, DATA_MAX));
   endfunction

   // mostly well-formed messages with random content, plus broken ones and noise
   task automatic send_random_message();
      int         pick;
      int         n;
      logic [7:0] status;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         status = {4'($urandom_range(KIND_NOTE_OFF, KIND_PITCH_BEND)),
                   4'($urandom_range(0, 15))};
         n = (status[7:4] == mbma_pkg::KIND_PROG_CHANGE ||
              status[7:4] == mbma_pkg::KIND_CH_PRESSURE) ? 1 : 2;
         // truncate or overrun now and then
         if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 3);
         send_byte(status);
         repeat (n) send_byte(random_data());
      end else if (pick < 62) begin
         case ($urandom_range(0, 2))
            0: begin
               send_byte(mbma_pkg::STATUS_SONG_POS);
               send_byte(random_data());
               send_byte(random_data());
            end
            1: begin
               send_byte(mbma_pkg::STATUS_SONG_SEL);
               send_byte(random_data());
            end
            default: begin
               send_byte(mbma_pkg::STATUS_UNDEF);
               send_byte(random_data());
            end
         endcase
      end else if (pick < 77) begin
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MAX_MESSAGE_BYTES - 2)
                                          : $urandom_range(0, 8);
         send_byte(mbma_pkg::STATUS_SYSEX);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_byte(mbma_pkg::STATUS_NOTE_OFF_CH15);
            else send_byte(random_data());
         end
         // leave some unterminated
         if ($urandom_range(0, 9) != 0) send_byte(mbma_pkg::STATUS_EOX);
      end else if (pick < 87) begin
         send_byte(8'($urandom_range(SINGLE_BYTE_FIRST, BYTE_MAX)));
      end else begin
         send_byte(8'($urandom_range(0, BYTE_MAX)));
      end
   endtask

   task automatic run_random_phase(input int gap, input int stall, input int count);
      int start;
      max_req_gap = gap;
      max_rsp_stall = stall;
      start = bytes_sent;
      while (bytes_sent - start < count) send_random_message();
   endtask

   task automatic test_port_closed();
      logic [7:0] seq [5];
      seq = '{NOTE_ON_CH0, 8'h10, 8'h20, mbma_pkg::STATUS_SYSEX, mbma_pkg::STATUS_EOX};
      foreach (seq[i]) send_byte(seq[i]);
      drain_results();
   endtask

   task automatic test_directed_bytes();
      logic [7:0] seq [27];
      seq = '{8'h00, mbma_pkg::STATUS_NOTE_OFF_CH15,
              NOTE_OFF_CH0, 8'h00, 8'h7F,
              {mbma_pkg::KIND_PROG_CHANGE, 4'h5}, 8'h12,
              mbma_pkg::STATUS_SONG_POS, 8'h10, 8'h20,
              mbma_pkg::STATUS_SONG_SEL, 8'h05,
              mbma_pkg::STATUS_UNDEF, 8'h01,
              SYSTEM_RESET, TUNE_REQUEST,
              mbma_pkg::STATUS_SYSEX, 8'h7D, mbma_pkg::STATUS_NOTE_OFF_CH15, 8'h01,
              mbma_pkg::STATUS_EOX,
              mbma_pkg::STATUS_EOX,
              NOTE_ON_CH0, mbma_pkg::STATUS_NOTE_OFF_CH15,
              NOTE_ON_CH0, 8'h40, mbma_pkg::STATUS_NOTE_OFF_CH15};
      write_port_open(1'b1);
      foreach (seq[i]) send_byte(seq[i]);
      drain_results();
   endtask

   // hold the receiver off while a full-size sysex and more traffic pile up
   task automatic test_output_backpressure();
      max_req_gap = 0;
      max_rsp_stall = 0;
      rsp_hold_request = LONG_HOLD_CYCLES;
      send_byte(mbma_pkg::STATUS_SYSEX);
      repeat (MAX_MESSAGE_BYTES - 2) send_byte(random_data());
      send_byte(mbma_pkg::STATUS_EOX);
      send_byte(NOTE_ON_CH0);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte({mbma_pkg::KIND_PROG_CHANGE, 4'h0});
      send_byte(8'h03);
      drain_results();
   endtask

   // one byte past a full buffer throws the whole message away
   task automatic test_sysex_overflow();
      max_req_gap = 2;
      max_rsp_stall = 2;
      send_byte(mbma_pkg::STATUS_SYSEX);
      repeat (MAX_MESSAGE_BYTES - 1) send_byte(random_data());
      send_byte(mbma_pkg::STATUS_EOX);
      send_byte(8'h22);
      send_byte(NOTE_ON_CH0);
      send_byte(8'h01);
      send_byte(8'h02);
      drain_results();
   endtask

   task automatic test_random_traffic();
      run_random_phase(6, 6, 24);
      run_random_phase(0, 0, 10);
      drain_results();
      write_port_open(1'b0);
      run_random_phase(6, 0, 8);
      drain_results();
      write_port_open(1'b1);
      run_random_phase(0, 6, 10);
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_port_closed();
      test_directed_bytes();
      test_output_backpressure();
      test_sysex_overflow();
      test_random_traffic();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d expected bytes never came out",
                                   expected_bytes.size()));
      $display("run covered %0d input bytes, %0d output bytes in %0d messages",
               bytes_sent, results_checked, messages_seen);
      $display("port closed and open, full-size sysex under a long stall, overflow; %0d errors",
               error_count);
      if (error_count == 0) begin
         $display("midi_byte_message_assembler_tb: PASS");
      end else begin
         $display("midi_byte_message_assembler_tb: FAIL");
      end
      $finish;
   end

endmodule
